@@ sv/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising clock edge outside reset
`define TAS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// condition that must never be seen outside reset
`define TAS_NEVER(label, expr) \
   `TAS_ASSERT(label, !(expr))

`else

`define TAS_ASSERT(label, prop)
`define TAS_NEVER(label, expr)

`endif

`endif

@@ sv/tas_pkg.sv @@
package tas_pkg;

   // cordic setup
   localparam int CORDIC_STEPS = 14;
   localparam int ITER_W       = $clog2(CORDIC_STEPS);
   localparam int XW           = 44;
   localparam int ZW           = 24;
   localparam logic [13:0] HALF_PI_Q12 = 14'd6434;
   localparam logic [15:0] AGE_STALE   = 16'hFFFF;

   // item modes
   localparam logic [1:0] MODE_CMD    = 2'd0;
   localparam logic [1:0] MODE_REPORT = 2'd1;
   localparam logic [1:0] MODE_TICK   = 2'd2;

   // register indexes
   localparam logic [2:0] REG_WHEELBASE   = 3'd0;
   localparam logic [2:0] REG_MIN_RADIUS  = 3'd1;
   localparam logic [2:0] REG_MOVING_LIM  = 3'd2;
   localparam logic [2:0] REG_FOLLOW_TOL  = 3'd3;
   localparam logic [2:0] REG_STOPPED_TOL = 3'd4;
   localparam logic [2:0] REG_CMD_TIMEOUT = 3'd5;
   localparam logic [2:0] REG_RPT_TIMEOUT = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_INIT,
      ST_ITER,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic load_prod;
      logic init_cordic;
      logic iterate;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic launch;
      logic iter_last;
      logic out_busy;
   } dp_status_type;

   // atan(2^-i) in Q.20 radians
   function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] idx);
      logic signed [ZW-1:0] val;
      case (idx)
         5'd0:  val = 24'sd823550;
         5'd1:  val = 24'sd486170;
         5'd2:  val = 24'sd256879;
         5'd3:  val = 24'sd130396;
         5'd4:  val = 24'sd65451;
         5'd5:  val = 24'sd32757;
         5'd6:  val = 24'sd16383;
         5'd7:  val = 24'sd8192;
         5'd8:  val = 24'sd4096;
         5'd9:  val = 24'sd2048;
         5'd10: val = 24'sd1024;
         5'd11: val = 24'sd512;
         5'd12: val = 24'sd256;
         5'd13: val = 24'sd128;
         5'd14: val = 24'sd64;
         5'd15: val = 24'sd32;
         5'd16: val = 24'sd16;
         5'd17: val = 24'sd8;
         5'd18: val = 24'sd4;
         5'd19: val = 24'sd2;
         default: val = '0;
      endcase
      return val;
   endfunction

   // saturating age step
   function automatic logic [15:0] age_inc(input logic [15:0] age);
      return (age == AGE_STALE) ? AGE_STALE : age + 16'd1;
   endfunction

endpackage

@@ sv/tas_req_if.sv @@
interface tas_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        mode;
   logic signed [15:0] cmd_speed;
   logic signed [15:0] cmd_turn_rate;
   logic signed [15:0] report_speed;
   logic signed [15:0] report_steering;

   modport source (output valid, mode, cmd_speed, cmd_turn_rate, report_speed,
                   report_steering, input ready);
   modport sink (input valid, mode, cmd_speed, cmd_turn_rate, report_speed,
                 report_steering, output ready);
endinterface

@@ sv/tas_rsp_if.sv @@
interface tas_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [13:0] steer_angle;
   logic signed [15:0] drive_speed;
   logic              radius_rejected;
   logic              aligned;

   modport source (output valid, steer_angle, drive_speed, radius_rejected, aligned,
                   input ready);
   modport sink (input valid, steer_angle, drive_speed, radius_rejected, aligned,
                 output ready);
endinterface

@@ sv/tas_csr_if.sv @@
interface tas_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ sv/tas_ctrl.sv @@
module tas_ctrl import tas_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.launch) state_in = ST_MULT;
         end
         ST_MULT: state_in = ST_INIT;
         ST_INIT: state_in = ST_ITER;
         ST_ITER: begin
            if (status.iter_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_MULT: cmd.load_prod   = 1'b1;
         ST_INIT: cmd.init_cordic = 1'b1;
         ST_ITER: cmd.iterate     = 1'b1;
         ST_DONE: cmd.finish      = !status.out_busy;
         default: cmd = '0;
      endcase
   end

endmodule

@@ sv/tas_dp.sv @@
module tas_dp import tas_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   input  logic [1:0]         req_mode,
   input  logic signed [15:0] req_cmd_speed,
   input  logic signed [15:0] req_cmd_turn_rate,
   input  logic signed [15:0] req_report_speed,
   input  logic signed [15:0] req_report_steering,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [13:0] rsp_steer_angle,
   output logic signed [15:0] rsp_drive_speed,
   output logic               rsp_radius_rejected,
   output logic               rsp_aligned
);

   // configuration
   logic [15:0] wheelbase_ff, min_radius_ff, cmd_timeout_ff, rpt_timeout_ff;
   logic [14:0] moving_lim_ff, follow_tol_ff, stopped_tol_ff;
   // held state
   logic signed [15:0] held_speed_ff, held_turn_ff, seen_speed_ff, seen_steer_ff;
   logic [15:0]        cmd_age_ff, rpt_age_ff;
   // working registers
   logic [31:0]           prod_ff, rhs_ff;
   logic                  reject_ff, skip_ff;
   logic signed [XW-1:0]  x_ff, y_ff;
   logic signed [ZW-1:0]  z_ff;
   logic [ITER_W-1:0]     iter_ff;
   // result register
   logic                  rsp_valid_ff;
   logic signed [13:0]    rsp_steer_ff;
   logic signed [15:0]    rsp_speed_ff;
   logic                  rsp_reject_ff, rsp_aligned_ff;

   logic [15:0] cmd_age_in, speed_abs, turn_abs, seen_abs;
   logic [24:0] lhs;
   logic        reject_in, skip_in, y_neg;
   logic [39:0] y_mag;
   logic signed [XW-1:0] dx, dy;
   logic signed [ZW-1:0] atan_val;
   logic [ZW-1:0]        z_abs;
   logic [ZW-1:0]        r_full;
   logic [13:0]          r_clamp;
   logic signed [13:0]   steer;
   logic                 fresh_rpt, aligned;
   logic [14:0]          tol;
   logic signed [16:0]   diff;
   logic [16:0]          diff_abs;

   // item decode status
   assign cmd_age_in       = age_inc(cmd_age_ff);
   assign status.launch    = (req_mode == MODE_TICK) && (cmd_age_in != AGE_STALE)
                             && (cmd_age_in <= cmd_timeout_ff);
   assign status.iter_last = (iter_ff == ITER_W'(CORDIC_STEPS - 1));
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         wheelbase_ff   <= 16'd4096;
         min_radius_ff  <= 16'd256;
         moving_lim_ff  <= 15'd205;
         follow_tol_ff  <= 15'd1638;
         stopped_tol_ff <= 15'd205;
         cmd_timeout_ff <= 16'd200;
         rpt_timeout_ff <= 16'd200;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_WHEELBASE:   wheelbase_ff   <= csr_data;
            REG_MIN_RADIUS:  min_radius_ff  <= csr_data;
            REG_MOVING_LIM:  moving_lim_ff  <= csr_data[14:0];
            REG_FOLLOW_TOL:  follow_tol_ff  <= csr_data[14:0];
            REG_STOPPED_TOL: stopped_tol_ff <= csr_data[14:0];
            REG_CMD_TIMEOUT: cmd_timeout_ff <= csr_data;
            REG_RPT_TIMEOUT: rpt_timeout_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // latch commands and reports, age on ticks
   always_ff @(posedge clock) begin
      if (reset) begin
         held_speed_ff <= '0;
         held_turn_ff  <= '0;
         seen_speed_ff <= '0;
         seen_steer_ff <= '0;
         cmd_age_ff    <= AGE_STALE;
         rpt_age_ff    <= AGE_STALE;
      end else if (cmd.accept) begin
         case (req_mode)
            MODE_CMD: begin
               held_speed_ff <= req_cmd_speed;
               held_turn_ff  <= req_cmd_turn_rate;
               cmd_age_ff    <= '0;
            end
            MODE_REPORT: begin
               seen_speed_ff <= req_report_speed;
               seen_steer_ff <= req_report_steering;
               rpt_age_ff    <= '0;
            end
            MODE_TICK: begin
               cmd_age_ff <= cmd_age_in;
               rpt_age_ff <= age_inc(rpt_age_ff);
            end
            default: ;
         endcase
      end
   end

   // magnitudes of the held command
   assign speed_abs = held_speed_ff[15] ? 16'(-held_speed_ff) : held_speed_ff;
   assign turn_abs  = held_turn_ff[15] ? 16'(-held_turn_ff) : held_turn_ff;

   // products for the radius check and the tangent numerator
   always_ff @(posedge clock) begin
      if (cmd.load_prod) begin
         prod_ff <= wheelbase_ff * turn_abs;
         rhs_ff  <= min_radius_ff * turn_abs;
      end
   end

   // radius reject and trivial-angle cases
   assign lhs       = {1'b0, speed_abs, 8'b0};
   assign reject_in = (held_turn_ff != '0) && ({7'b0, lhs} < rhs_ff);
   assign skip_in   = (held_turn_ff == '0) || reject_in
                      || ((speed_abs == '0) && (prod_ff == '0));
   assign y_neg     = held_turn_ff[15] ^ held_speed_ff[15];
   assign y_mag     = {prod_ff, 8'b0};

   // cordic shift-add step
   assign dx       = y_ff >>> iter_ff;
   assign dy       = x_ff >>> iter_ff;
   assign atan_val = atan_q20(5'(iter_ff));

   always_ff @(posedge clock) begin
      if (cmd.init_cordic) begin
         x_ff      <= XW'({speed_abs, 20'b0});
         y_ff      <= y_neg ? -XW'(y_mag) : XW'(y_mag);
         z_ff      <= '0;
         iter_ff   <= '0;
         reject_ff <= reject_in;
         skip_ff   <= skip_in;
      end else if (cmd.iterate) begin
         if (!y_ff[XW-1]) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + atan_val;
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - atan_val;
         end
         if (!status.iter_last) iter_ff <= iter_ff + 1'b1;
      end
   end

   // round to Q1.12 and clamp
   assign z_abs   = z_ff[ZW-1] ? -z_ff : z_ff;
   assign r_full  = (z_abs + ZW'(128)) >> 8;
   assign r_clamp = (r_full > ZW'(HALF_PI_Q12)) ? HALF_PI_Q12 : r_full[13:0];
   assign steer   = skip_ff ? '0 : (z_ff[ZW-1] ? -r_clamp : r_clamp);

   // alignment against the latest report
   assign fresh_rpt = (rpt_age_ff != AGE_STALE) && (rpt_age_ff <= rpt_timeout_ff);
   assign seen_abs  = seen_speed_ff[15] ? 16'(-seen_speed_ff) : seen_speed_ff;
   assign tol       = (seen_abs > {1'b0, moving_lim_ff}) ? follow_tol_ff : stopped_tol_ff;
   assign diff      = 17'(seen_steer_ff) - 17'(steer);
   assign diff_abs  = diff[16] ? 17'(-diff) : diff;
   assign aligned   = fresh_rpt && (diff_abs < {2'b0, tol});

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_steer_ff   <= steer;
         rsp_speed_ff   <= (aligned && !reject_ff) ? held_speed_ff : '0;
         rsp_reject_ff  <= reject_ff;
         rsp_aligned_ff <= aligned;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_steer_angle     = rsp_steer_ff;
   assign rsp_drive_speed     = rsp_speed_ff;
   assign rsp_radius_rejected = rsp_reject_ff;
   assign rsp_aligned         = rsp_aligned_ff;

endmodule

@@ sv/twist_to_ackermann_steering.sv @@
// channel    dir  handshake     payload
// req_ch     in   valid/ready   mode, cmd_speed, cmd_turn_rate, report_speed, report_steering
// rsp_ch     out  valid/ready   steer_angle, drive_speed, radius_rejected, aligned
// csr_ch     in   valid/ready   index, data
//
// commands, reports and stale ticks are taken in the idle state, which then accepts the next item
// a fresh tick steps through the mult, init, iter and done states, the iter state running the iterative cordic unit
// the result register holds one result; a new item is accepted while it waits
// reset is synchronous and restores register defaults and stale ages
// csr writes are taken every cycle
`include "assert_macros.svh"

module twist_to_ackermann_steering import tas_pkg::*; (
   input logic       clock,
   input logic       reset,
   tas_req_if.sink   req_ch,
   tas_rsp_if.source rsp_ch,
   tas_csr_if.sink   csr_ch
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ch.ready = 1'b1;

   // sequencer
   tas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   tas_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_mode            (req_ch.mode),
      .req_cmd_speed       (req_ch.cmd_speed),
      .req_cmd_turn_rate   (req_ch.cmd_turn_rate),
      .req_report_speed    (req_ch.report_speed),
      .req_report_steering (req_ch.report_steering),
      .csr_write           (csr_ch.valid),
      .csr_index           (csr_ch.index),
      .csr_data            (csr_ch.data),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_steer_angle     (rsp_ch.steer_angle),
      .rsp_drive_speed     (rsp_ch.drive_speed),
      .rsp_radius_rejected (rsp_ch.radius_rejected),
      .rsp_aligned         (rsp_ch.aligned)
   );

   // result sanity
   `TAS_ASSERT(a_steer_range, rsp_ch.valid |-> (rsp_ch.steer_angle <= 14'sd6434 && rsp_ch.steer_angle >= -14'sd6434))
   `TAS_ASSERT(a_reject_zero, rsp_ch.valid && rsp_ch.radius_rejected |-> rsp_ch.steer_angle == '0 && rsp_ch.drive_speed == '0)
   `TAS_ASSERT(a_unaligned_stop, rsp_ch.valid && !rsp_ch.aligned |-> rsp_ch.drive_speed == '0)
   `TAS_ASSERT(a_finish_shows, cmd.finish |=> rsp_ch.valid)
   `TAS_NEVER(a_finish_overrun, cmd.finish && rsp_ch.valid && !rsp_ch.ready)

endmodule
